### rtl/core/rfld_pkg.sv
// Package for the ranging frame and line demultiplexer.
// Holds the result kind codes, the protocol byte constants and the result record type.
// Depends on nothing.
`default_nettype none

package rfld_pkg;

	// Result kind codes.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_REPORT    = 2'd0;
	localparam kind_t KIND_CHAR      = 2'd1;
	localparam kind_t KIND_LINE_END  = 2'd2;
	localparam kind_t KIND_MALFORMED = 2'd3;

	// Protocol bytes.
	localparam logic [7:0] HEADER_BYTE = 8'hF0;
	localparam logic [7:0] FRAME_TAG   = 8'h05;
	localparam logic [7:0] FRAME_TAIL  = 8'hAA;
	localparam logic [7:0] NEWLINE     = 8'h0A;
	localparam logic [7:0] CARRIAGE    = 8'h0D;

	// A frame is the header plus seven bytes. Bytes 1 to 6 are stored, and byte 7
	// is checked as it arrives.
	localparam int unsigned FRAME_BYTES  = 8;
	localparam int unsigned STORE_BYTES  = FRAME_BYTES - 2;
	localparam int unsigned FCNT_W       = 3;
	localparam logic [FCNT_W-1:0] LAST_FRAME_IDX = FCNT_W'(FRAME_BYTES - 2);

	// One result transaction.
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         line_char;
		logic               line_last;
		logic [15:0]        src_addr;
		logic [15:0]        range_len;
		logic signed [7:0]  rx_level;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/ranging_frame_and_line_demux.sv
// Top level of the ranging frame and line demultiplexer.
// Uses rfld_pkg for kind codes, protocol bytes and the result record.
`default_nettype none

// The block takes received serial bytes and returns at most one result per byte: a
// ranging report, a line character, a bare line end or a malformed frame flag. Parsing
// state is updated in the cycle a byte is accepted, and the result is registered in
// the output register feeding the result port. A skid register behind it lets the
// block keep accepting bytes while a result waits; byte_stall rises only when both
// are full. The sustained rate is one byte per cycle while result_stall is low. Line
// characters come out one byte late, so the last character of a line is marked when
// the newline arrives; a trailing carriage return is dropped. Lines are limited to
// LINE_BUF_BYTES-1 stored bytes, and further bytes of a long line are dropped.
module ranging_frame_and_line_demux #(
	parameter int unsigned LINE_BUF_BYTES = 512
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire logic [7:0]          data_byte,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output rfld_pkg::kind_t          kind,
	output logic [7:0]               line_char,
	output logic                     line_last,
	output logic [15:0]              src_addr,
	output logic [15:0]              range_len,
	output logic signed [7:0]        rx_level
);
	import rfld_pkg::*;

	localparam int unsigned LCNT_W = $clog2(LINE_BUF_BYTES);
	localparam logic [LCNT_W-1:0] LINE_MAX = LCNT_W'(LINE_BUF_BYTES - 1);

	logic                 in_frame_q;
	logic [FCNT_W-1:0]    frame_cnt_q;
	logic [7:0]           frame_store_q [STORE_BYTES];
	logic [LCNT_W-1:0]    line_cnt_q;
	logic [7:0]           held_char_q;

	logic                 out_vld_q;
	result_t              out_q;
	logic                 skid_vld_q;
	result_t              skid_q;

	logic                 byte_acc;
	logic                 out_take;
	logic                 res_vld;
	result_t              res;

	assign byte_stall = skid_vld_q;
	assign byte_acc   = byte_valid && !byte_stall;
	assign out_take   = out_vld_q && !result_stall;

	// Result for the byte at the input, from the current parsing state.
	always_comb begin
		res     = '0;
		res_vld = 1'b0;
		if (in_frame_q) begin
			if (frame_cnt_q == LAST_FRAME_IDX) begin
				res_vld = 1'b1;
				if (frame_store_q[0] == FRAME_TAG && data_byte == FRAME_TAIL) begin
					res.kind      = KIND_REPORT;
					res.src_addr  = {frame_store_q[2], frame_store_q[1]};
					res.range_len = {frame_store_q[4], frame_store_q[3]};
					res.rx_level  = frame_store_q[5];
				end else begin
					res.kind = KIND_MALFORMED;
				end
			end
		end else if (data_byte == HEADER_BYTE && line_cnt_q == '0) begin
			res_vld = 1'b0;
		end else if (data_byte == NEWLINE) begin
			res_vld = 1'b1;
			if (line_cnt_q != '0 && held_char_q != CARRIAGE) begin
				res.kind      = KIND_CHAR;
				res.line_char = held_char_q;
				res.line_last = 1'b1;
			end else begin
				res.kind = KIND_LINE_END;
			end
		end else if (line_cnt_q < LINE_MAX && line_cnt_q != '0) begin
			res_vld       = 1'b1;
			res.kind      = KIND_CHAR;
			res.line_char = held_char_q;
		end
	end

	// Parsing state update on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			frame_cnt_q <= '0;
			line_cnt_q  <= '0;
		end else if (byte_acc) begin
			if (in_frame_q) begin
				if (frame_cnt_q == LAST_FRAME_IDX) begin
					in_frame_q  <= 1'b0;
					frame_cnt_q <= '0;
				end else begin
					frame_cnt_q <= frame_cnt_q + 1'b1;
				end
			end else if (data_byte == HEADER_BYTE && line_cnt_q == '0) begin
				in_frame_q  <= 1'b1;
				frame_cnt_q <= '0;
			end else if (data_byte == NEWLINE) begin
				line_cnt_q <= '0;
			end else if (line_cnt_q < LINE_MAX) begin
				line_cnt_q <= line_cnt_q + 1'b1;
			end
		end
	end

	// Frame bytes and the held line character need no reset.
	always_ff @(posedge clk) begin
		if (byte_acc) begin
			if (in_frame_q && frame_cnt_q != LAST_FRAME_IDX) begin
				frame_store_q[frame_cnt_q] <= data_byte;
			end
			if (!in_frame_q && !(data_byte == HEADER_BYTE && line_cnt_q == '0)
					&& data_byte != NEWLINE && line_cnt_q < LINE_MAX) begin
				held_char_q <= data_byte;
			end
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_take) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || out_take) begin
			out_vld_q <= byte_acc && res_vld;
		end else if (byte_acc && res_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (!out_vld_q || out_take) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

	assign result_valid = out_vld_q;
	assign kind         = out_q.kind;
	assign line_char    = out_q.line_char;
	assign line_last    = out_q.line_last;
	assign src_addr     = out_q.src_addr;
	assign range_len    = out_q.range_len;
	assign rx_level     = out_q.rx_level;

	// The skid register fills only behind a full output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register holds a result while the output register is empty");

	// A frame opens only between lines, and no line bytes are counted inside it.
	a_frame_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> line_cnt_q == '0)
		else $error("line count is nonzero while a frame is open");

	// The frame counter rests at zero outside a frame and stays within the frame.
	a_frame_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_frame_q |-> frame_cnt_q == '0) and (frame_cnt_q <= LAST_FRAME_IDX))
		else $error("frame counter out of range");

endmodule

`default_nettype wire
